// ===== rtl/ctss_pkg.sv =====
// Shared types, key codes and digit limits for the clock time set sequencer.
// No dependencies; imported by ctss_step and clock_time_set_sequencer_core.
package ctss_pkg;

  typedef logic [3:0] digit_t;

  typedef enum logic [1:0] {
    KEY_NONE   = 2'd0,
    KEY_UP     = 2'd1,
    KEY_DOWN   = 2'd2,
    KEY_SELECT = 2'd3
  } key_t;

  localparam logic       OP_START     = 1'b0;
  localparam logic [2:0] STAGE_IDLE   = 3'd4;
  localparam digit_t     BLANK_CODE   = 4'd10;
  localparam logic [15:0] BLINK_RESET = 16'd200;

  localparam digit_t TOP_HOUR_TENS  = 4'd2;
  localparam digit_t TOP_HOUR_UNITS = 4'd9;
  localparam digit_t TOP_HOUR_LATE  = 4'd3;
  localparam digit_t TOP_MIN_TENS   = 4'd5;
  localparam digit_t TOP_MIN_UNITS  = 4'd9;

  typedef struct packed {
    logic   opcode;
    key_t   key;
    logic   tick;
    digit_t cur_hour_tens;
    digit_t cur_hour_units;
    digit_t cur_min_tens;
    digit_t cur_min_units;
  } item_t;

  typedef struct packed {
    logic [2:0]        stage;
    digit_t [3:0]      digits;
    digit_t            orig_hour_units;
    logic              blank_phase;
    logic [15:0]       blink_count;
  } edit_state_t;

  typedef struct packed {
    digit_t [3:0] show;
    logic [2:0]   edit_position;
    logic         commit;
  } result_t;

  function automatic digit_t sat_digit(input digit_t v, input digit_t top);
    return (v > top) ? top : v;
  endfunction

endpackage

// ===== rtl/ctss_step.sv =====
// Next-state and result logic for one item of the time set sequencer.
// Purely combinational; depends on ctss_pkg.
module ctss_step (
  input  ctss_pkg::item_t       item,
  input  ctss_pkg::edit_state_t cur,
  input  logic [15:0]           blink_interval,
  output ctss_pkg::edit_state_t nxt,
  output ctss_pkg::result_t     res
);
  import ctss_pkg::*;

  logic [1:0]  pos;
  logic [15:0] count_tick;
  digit_t      top;
  digit_t      start_hour_tens;
  digit_t      start_hour_units;

  assign pos = cur.stage[1:0];
  assign count_tick = (item.tick && (cur.blink_count != 16'hFFFF))
                      ? cur.blink_count + 16'd1 : cur.blink_count;
  assign start_hour_tens  = sat_digit(item.cur_hour_tens, TOP_HOUR_TENS);
  assign start_hour_units = sat_digit(item.cur_hour_units, TOP_HOUR_UNITS);

  always_comb begin
    case (pos)
      2'd0:    top = TOP_HOUR_TENS;
      2'd1:    top = (cur.digits[0] == TOP_HOUR_TENS) ? TOP_HOUR_LATE : TOP_HOUR_UNITS;
      2'd2:    top = TOP_MIN_TENS;
      default: top = TOP_MIN_UNITS;
    endcase
  end

  always_comb begin
    nxt = cur;
    res.commit = 1'b0;
    if (item.opcode == OP_START) begin
      nxt.digits[0] = start_hour_tens;
      nxt.orig_hour_units = start_hour_units;
      nxt.digits[1] = (start_hour_tens == TOP_HOUR_TENS)
                      ? sat_digit(start_hour_units, TOP_HOUR_LATE) : start_hour_units;
      nxt.digits[2] = sat_digit(item.cur_min_tens, TOP_MIN_TENS);
      nxt.digits[3] = sat_digit(item.cur_min_units, TOP_MIN_UNITS);
      nxt.stage = 3'd0;
      nxt.blank_phase = 1'b0;
      nxt.blink_count = 16'd0;
    end else if (cur.stage < STAGE_IDLE) begin
      // Blink update happens before the key is handled.
      nxt.blink_count = count_tick;
      if (count_tick >= blink_interval) begin
        nxt.blank_phase = ~cur.blank_phase;
        nxt.blink_count = 16'd0;
      end
      case (item.key)
        KEY_UP: begin
          if (cur.digits[pos] < top) begin
            nxt.digits[pos] = cur.digits[pos] + 4'd1;
            nxt.blink_count = blink_interval;
            if ((pos == 2'd0) && (cur.digits[0] + 4'd1 == TOP_HOUR_TENS) &&
                (cur.digits[1] > TOP_HOUR_LATE)) begin
              nxt.digits[1] = 4'd0;
            end
          end
        end
        KEY_DOWN: begin
          if (cur.digits[pos] != 4'd0) begin
            nxt.digits[pos] = cur.digits[pos] - 4'd1;
            nxt.blink_count = blink_interval;
            // Lowering hour tens brings back the hour units loaded at start.
            if (pos == 2'd0) begin
              nxt.digits[1] = cur.orig_hour_units;
            end
          end
        end
        KEY_SELECT: begin
          nxt.stage = cur.stage + 3'd1;
          nxt.blank_phase = 1'b0;
          nxt.blink_count = 16'd0;
          if (pos == 2'd3) begin
            nxt.stage = STAGE_IDLE;
            res.commit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    for (int j = 0; j < 4; j++) begin
      res.show[j] = ((nxt.stage == 3'(j)) && nxt.blank_phase) ? BLANK_CODE : nxt.digits[j];
    end
    res.edit_position = nxt.stage;
  end

endmodule

// ===== rtl/clock_time_set_sequencer_core.sv =====
// Clock time set sequencer: steps a user through setting HH:MM digit by digit.
// The result of an accepted item appears on the output register in the cycle after it is accepted.
// Throughput: one item per cycle unless the output stalls; the edit state updates in the accepting cycle.
// Reset (rst, synchronous): idle, digits zero, blink interval 200, no result held.
// Depends on ctss_pkg and ctss_step.
module clock_time_set_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,      // blink_interval
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,        // key_code[1:0], tick, cur_hour_tens[1:0],
                                      // cur_hour_units[3:0], cur_min_tens[2:0],
                                      // cur_min_units[3:0]
  input  logic [0:0]  s_tuser,        // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata         // show_hour_tens[3:0], show_hour_units[3:0],
                                      // show_min_tens[3:0], show_min_units[3:0],
                                      // edit_position[2:0], commit, new_hour_tens[1:0],
                                      // new_hour_units[3:0], new_min_tens[2:0],
                                      // new_min_units[3:0], zero fill
);
  import ctss_pkg::*;

  logic [15:0] blink_interval;
  edit_state_t state;
  edit_state_t state_next;
  item_t       item;
  result_t     res;
  logic        accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign item.opcode         = s_tuser[0];
  assign item.key            = key_t'(s_tdata[1:0]);
  assign item.tick           = s_tdata[2];
  assign item.cur_hour_tens  = {2'b00, s_tdata[4:3]};
  assign item.cur_hour_units = s_tdata[8:5];
  assign item.cur_min_tens   = {1'b0, s_tdata[11:9]};
  assign item.cur_min_units  = s_tdata[15:12];

  ctss_step u_step (
    .item           (item),
    .cur            (state),
    .blink_interval (blink_interval),
    .nxt            (state_next),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_interval <= BLINK_RESET;
    end else if (cfg_we) begin
      blink_interval <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.stage           <= STAGE_IDLE;
      state.digits          <= '0;
      state.orig_hour_units <= '0;
      state.blank_phase     <= 1'b0;
      state.blink_count     <= '0;
      m_tvalid              <= 1'b0;
    end else if (accept) begin
      state    <= state_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {7'd0,
                  state_next.digits[3],
                  state_next.digits[2][2:0],
                  state_next.digits[1],
                  state_next.digits[0][1:0],
                  res.commit,
                  res.edit_position,
                  res.show[3], res.show[2], res.show[1], res.show[0]};
    end
  end

endmodule
